// File: design/dot_offset_direction_quantizer_macros.svh
// ----------------------------------------------------------------------------
// Dot offset direction quantizer: assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef DOT_OFFSET_DIRECTION_QUANTIZER_MACROS_SVH
`define DOT_OFFSET_DIRECTION_QUANTIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, switched off while arst_n is low.
`define DOQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, switched off while arst_n is low.
`define DOQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/doq_pkg.sv
// ----------------------------------------------------------------------------
// Dot offset direction quantizer: shared package
// Widths, angle constants, the arctangent table, direction codes and the
// records that travel along the rotation chain.
// ----------------------------------------------------------------------------
package doq_pkg;

	// Columns of the subset window that the baseline mask covers.
	localparam int unsigned SUB_COLS = 8;

	// Rotation datapath widths: x and y need 27 signed bits after the CORDIC
	// gain, the angle accumulator 23 signed bits.
	localparam int unsigned XW = 27;
	localparam int unsigned ZW = 23;
	localparam int unsigned ATAN_W = 21;
	localparam int unsigned ATAN_N = 20;
	localparam int unsigned ANG_FRAC = 8;
	localparam int unsigned ROUND_HALF = 128;

	// atan(2^-i) in 1/32768 degree, rounded to nearest.
	localparam logic [ATAN_W-1:0] ATAN_TAB [0:ATAN_N-1] = '{
		21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189,
		21'd58652, 21'd29333, 21'd14667, 21'd7334, 21'd3667,
		21'd1833, 21'd917, 21'd458, 21'd229, 21'd115,
		21'd57, 21'd29, 21'd14, 21'd7, 21'd4
	};

	// Angles in 1/128 degree.
	localparam logic signed [15:0] HALF_SECTOR = 16'sd2880;
	localparam logic signed [15:0] DEG45 = 16'sd5760;
	localparam logic signed [15:0] DEG90 = 16'sd11520;
	localparam logic signed [15:0] DEG135 = 16'sd17280;
	localparam logic signed [15:0] DEG180 = 16'sd23040;
	localparam logic [11:0] ERR_MAX = 12'd2880;

	// Direction codes.
	typedef logic [3:0] dir_t;
	localparam dir_t DIR_CENTRE = 4'd0;
	localparam dir_t DIR_LEFT = 4'd1;
	localparam dir_t DIR_BOTTOM = 4'd2;
	localparam dir_t DIR_RIGHT = 4'd3;
	localparam dir_t DIR_TOP = 4'd4;
	localparam dir_t DIR_LEFT_TOP = 4'd5;
	localparam dir_t DIR_RIGHT_TOP = 4'd6;
	localparam dir_t DIR_RIGHT_BOTTOM = 4'd7;
	localparam dir_t DIR_LEFT_BOTTOM = 4'd8;

	// Configuration register indexes (paddr[2]) and reset values.
	localparam logic REG_MAX_ERR = 1'b0;
	localparam logic REG_BASELINE = 1'b1;
	localparam logic [14:0] MAX_ERR_RESET = 15'd1280;

	// Per-dot flags that ride alongside the rotation.
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic base;
		logic first;
		logic last;
	} side_t;

	// One rotation vector with its flags.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		side_t side;
	} vec_t;

endpackage

// File: design/dot_offset_direction_quantizer.sv
// ----------------------------------------------------------------------------
// Dot offset direction quantizer: top level
// Classifies dot displacements into eight sectors and tracks the worst
// angular deviation of each subset against a threshold.
// ----------------------------------------------------------------------------
// The block takes one dot word per clock and returns one result word per
// dot, in order. Inside, a word passes the input register, which forms the
// absolute displacement, the cells of the rotation chain (CORDIC_ITERS
// cells, one micro-rotation each), the registers of the sector unit and the
// output register, where the running worst deviation and the failure flag
// of the subset are updated. Every stage holds its word while the output
// word is not taken, so s_tready falls only when the output register is
// full and m_tready is low. There is no clearing pass after reset. The two
// configuration registers should be written only while no word is in
// flight; max_angle_err sits at byte address 0 and baseline_mask at byte
// address 4.
module dot_offset_direction_quantizer #(
	parameter int unsigned CORDIC_ITERS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input dots.
	input  logic        s_tvalid,
	output logic        s_tready,
	// dot_x[15:0], dot_y[31:16], grid_x[47:32], grid_y[63:48],
	// column[67:64], zero[71:68]
	input  logic [71:0] s_tdata,
	// first_of_subset[0]
	input  logic        s_tuser,
	// last_of_row
	input  logic        s_tlast,
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	// direction[3:0], worst_err[15:4], row_fail[16], aborted[17], zero[23:18]
	output logic [23:0] m_tdata,
	// Configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import doq_pkg::*;

	// Configuration registers.
	logic [14:0] max_err_q;
	logic [15:0] baseline_q;
	logic        cfg_wr;

	// Global advance: everything moves unless the output word is stuck.
	logic adv;

	// Input preparation.
	logic [15:0] dot_x, dot_y, grid_x, grid_y;
	logic [3:0]  col;
	logic signed [16:0] dx, dy, adx, ady;
	logic        is_base;
	vec_t        vec_nxt;
	vec_t        vec_s1;
	logic        valid_s1;

	// Rotation chain.
	vec_t chain_vec [0:CORDIC_ITERS];
	logic chain_valid [0:CORDIC_ITERS];

	// Sector unit outputs.
	logic        sec_valid;
	dir_t        sec_dir;
	logic [11:0] sec_err;
	side_t       sec_side;

	// Subset state and its update.
	logic [11:0] worst_q;
	logic        failed_q;
	logic [11:0] base_worst;
	logic        base_failed;
	logic [11:0] new_worst;
	logic        row_fail;

	// Output register.
	logic        out_valid_q;
	dir_t        out_dir_q;
	logic [11:0] out_worst_q;
	logic        out_fail_q;
	logic        out_abort_q;

	// ------------------------------------------------------------------
	// APB configuration port. pready is tied high, so every access
	// completes in its access cycle.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_err_q <= MAX_ERR_RESET;
			baseline_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_ERR: max_err_q <= pwdata[14:0];
				REG_BASELINE: baseline_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_ERR: prdata = {17'd0, max_err_q};
			REG_BASELINE: prdata = {16'd0, baseline_q};
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input stage: exact 17-bit displacements, their magnitudes scaled by
	// 2^8 as the starting vector, and the baseline test on the column.
	// ------------------------------------------------------------------
	assign adv = ~out_valid_q | m_tready;
	assign s_tready = adv;

	assign dot_x = s_tdata[15:0];
	assign dot_y = s_tdata[31:16];
	assign grid_x = s_tdata[47:32];
	assign grid_y = s_tdata[63:48];
	assign col = s_tdata[67:64];

	always_comb begin
		dx = $signed({1'b0, dot_x}) - $signed({1'b0, grid_x});
		dy = $signed({1'b0, dot_y}) - $signed({1'b0, grid_y});
		adx = dx[16] ? -dx : dx;
		ady = dy[16] ? -dy : dy;
		// Columns beyond the window are never baseline columns.
		is_base = ({1'b0, col} < 5'(SUB_COLS)) && baseline_q[col];
		vec_nxt.x = $signed({{(XW - 16 - ANG_FRAC){1'b0}}, adx[15:0], {ANG_FRAC{1'b0}}});
		vec_nxt.y = $signed({{(XW - 16 - ANG_FRAC){1'b0}}, ady[15:0], {ANG_FRAC{1'b0}}});
		vec_nxt.z = '0;
		vec_nxt.side.neg_x = dx[16];
		vec_nxt.side.neg_y = dy[16];
		vec_nxt.side.base = is_base;
		vec_nxt.side.first = s_tuser;
		vec_nxt.side.last = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1 <= vec_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Rotation chain: cell g applies the micro-rotation by atan(2^-g).
	// A zero vector drives the angle negative, which the clamp in the
	// sector unit turns into zero, so it needs no special handling.
	// ------------------------------------------------------------------
	assign chain_vec[0] = vec_s1;
	assign chain_valid[0] = valid_s1;

	for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
		doq_cell #(
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.in_valid(chain_valid[g]),
			.in_vec(chain_vec[g]),
			.out_valid(chain_valid[g+1]),
			.out_vec(chain_vec[g+1])
		);
	end

	doq_sector u_sector (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(chain_valid[CORDIC_ITERS]),
		.in_vec(chain_vec[CORDIC_ITERS]),
		.out_valid(sec_valid),
		.dir(sec_dir),
		.err(sec_err),
		.side(sec_side)
	);

	// ------------------------------------------------------------------
	// Subset state. The first dot of a subset starts from a clean state;
	// baseline dots leave the worst deviation alone but still take part
	// in the row check. Aborted reports the failure flag as it stood
	// before this dot's own check.
	// ------------------------------------------------------------------
	always_comb begin
		base_worst = sec_side.first ? 12'd0 : worst_q;
		base_failed = sec_side.first ? 1'b0 : failed_q;
		new_worst = (!sec_side.base && (sec_err > base_worst)) ? sec_err : base_worst;
		row_fail = sec_side.last && ({3'd0, new_worst} > max_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worst_q <= '0;
			failed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sec_valid;
			if (sec_valid) begin
				worst_q <= new_worst;
				failed_q <= base_failed | row_fail;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_dir_q <= sec_dir;
			out_worst_q <= new_worst;
			out_fail_q <= row_fail;
			out_abort_q <= base_failed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, out_abort_q, out_fail_q, out_worst_q, out_dir_q};

endmodule

// File: design/doq_cell.sv
// ----------------------------------------------------------------------------
// Dot offset direction quantizer: rotation cell
// One vectoring CORDIC micro-rotation by atan(2^-IDX), registered.
// ----------------------------------------------------------------------------
module doq_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  doq_pkg::vec_t in_vec,
	output logic         out_valid,
	output doq_pkg::vec_t out_vec
);
	import doq_pkg::*;

	localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TAB[IDX]);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	vec_t nxt;

	// Arithmetic shifts round toward minus infinity, as the rotation needs.
	always_comb begin
		xs = in_vec.x >>> IDX;
		ys = in_vec.y >>> IDX;
		nxt = in_vec;
		if (in_vec.y > 0) begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + STEP;
		end else begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec <= nxt;
		end
	end

endmodule

// File: design/doq_sector.sv
// ----------------------------------------------------------------------------
// Dot offset direction quantizer: sector unit
// Rounds the first-quadrant angle, unfolds it to the full circle, picks the
// 45-degree sector and measures the deviation from its centre.
// ----------------------------------------------------------------------------
module doq_sector (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  doq_pkg::vec_t  in_vec,
	output logic          out_valid,
	output doq_pkg::dir_t  dir,
	output logic [11:0]   err,
	output doq_pkg::side_t side
);
	import doq_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic [13:0] t_s1;
	logic signed [15:0] d_s2, d_s3, cen_s3;
	dir_t dir_s3, dir_s4;
	logic [11:0] err_s4;

	logic signed [ZW-1:0] zr;
	logic [13:0] t_nxt;
	logic signed [15:0] ts;
	logic signed [15:0] d_nxt;
	dir_t dir_nxt;
	logic signed [15:0] cen_nxt;
	logic signed [16:0] diff;
	logic [16:0] adiff;
	logic [11:0] err_nxt;

	// Round half up to 1/128 degree and clamp to the first quadrant. The sum
	// stays signed so that the shift rounds a negative angle downwards.
	always_comb begin
		zr = (in_vec.z + $signed(ZW'(ROUND_HALF))) >>> ANG_FRAC;
		if (zr < 0) begin
			t_nxt = '0;
		end else if (zr > ZW'(DEG90)) begin
			t_nxt = DEG90[13:0];
		end else begin
			t_nxt = zr[13:0];
		end
	end

	// Place the angle in its quadrant from the displacement signs.
	always_comb begin
		ts = $signed({2'b00, t_s1});
		case ({side_s1.neg_x, side_s1.neg_y})
			2'b00: d_nxt = ts;
			2'b01: d_nxt = -ts;
			2'b10: d_nxt = DEG180 - ts;
			2'b11: d_nxt = ts - DEG180;
			default: d_nxt = ts;
		endcase
	end

	// Lower bounds inclusive, upper exclusive; left takes both ends.
	always_comb begin
		if (d_s2 < -DEG180 + HALF_SECTOR || d_s2 >= DEG180 - HALF_SECTOR) begin
			dir_nxt = DIR_LEFT;
			cen_nxt = d_s2[15] ? -DEG180 : DEG180;
		end else if (d_s2 >= DEG90 - HALF_SECTOR && d_s2 < DEG90 + HALF_SECTOR) begin
			dir_nxt = DIR_BOTTOM;
			cen_nxt = DEG90;
		end else if (d_s2 >= -HALF_SECTOR && d_s2 < HALF_SECTOR) begin
			dir_nxt = DIR_RIGHT;
			cen_nxt = '0;
		end else if (d_s2 >= -DEG90 - HALF_SECTOR && d_s2 < -DEG90 + HALF_SECTOR) begin
			dir_nxt = DIR_TOP;
			cen_nxt = -DEG90;
		end else if (d_s2 >= -DEG135 - HALF_SECTOR && d_s2 < -DEG135 + HALF_SECTOR) begin
			dir_nxt = DIR_LEFT_TOP;
			cen_nxt = -DEG135;
		end else if (d_s2 >= -DEG45 - HALF_SECTOR && d_s2 < -DEG45 + HALF_SECTOR) begin
			dir_nxt = DIR_RIGHT_TOP;
			cen_nxt = -DEG45;
		end else if (d_s2 >= DEG45 - HALF_SECTOR && d_s2 < DEG45 + HALF_SECTOR) begin
			dir_nxt = DIR_RIGHT_BOTTOM;
			cen_nxt = DEG45;
		end else begin
			dir_nxt = DIR_LEFT_BOTTOM;
			cen_nxt = DEG135;
		end
		if (side_s2.base) begin
			dir_nxt = DIR_CENTRE;
		end
	end

	always_comb begin
		diff = 17'(d_s3) - 17'(cen_s3);
		adiff = diff[16] ? 17'(-diff) : 17'(diff);
		err_nxt = (adiff > 17'(ERR_MAX)) ? ERR_MAX : adiff[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_nxt;
			side_s1 <= in_vec.side;
			d_s2 <= d_nxt;
			side_s2 <= side_s1;
			d_s3 <= d_s2;
			cen_s3 <= cen_nxt;
			dir_s3 <= dir_nxt;
			side_s3 <= side_s2;
			err_s4 <= err_nxt;
			dir_s4 <= dir_s3;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = valid_s4;
	assign dir = dir_s4;
	assign err = err_s4;
	assign side = side_s4;

endmodule

// File: design/doq_checker.sv
// ----------------------------------------------------------------------------
// Dot offset direction quantizer: port checker
// Watches the result stream of the top level and checks its fields.
// ----------------------------------------------------------------------------
`include "dot_offset_direction_quantizer_macros.svh"

module doq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import doq_pkg::*;

	// A result word that is not taken stays offered and unchanged.
	`DOQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

	// Direction codes run from centre to left-bottom only.
	`DOQ_ASSERT_NOW(a_dir_range, m_tvalid, m_tdata[3:0] <= DIR_LEFT_BOTTOM, "direction code out of range")

	// The deviation never exceeds half a sector.
	`DOQ_ASSERT_NOW(a_err_range, m_tvalid, m_tdata[15:4] <= ERR_MAX, "worst deviation above half a sector")

	// A row can only fail with a non-zero worst deviation.
	`DOQ_ASSERT_NOW(a_fail_err, m_tvalid && m_tdata[16], m_tdata[15:4] != 12'd0, "row failure with zero deviation")

endmodule

bind dot_offset_direction_quantizer doq_checker u_doq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
